// ----- sv/delivery_dedup_table_defines.svh -----
// ----------------------------------------------------------------------------
// Delivery dedup table assertion macros
// Concurrent assertion helpers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef DELIVERY_DEDUP_TABLE_DEFINES_SVH
`define DELIVERY_DEDUP_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define DDT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dedup table check failed");
`define DDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dedup table sequence check failed");
`else
`define DDT_ASSERT(label, clk, rst_n, prop)
`define DDT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/ddt_pkg.sv -----
// ----------------------------------------------------------------------------
// Delivery dedup table package
// Shared constants, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package ddt_pkg;

    localparam int TABLE_SLOTS_DEF  = 64;
    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int CFG_W            = 7;
    localparam int CNT_OUT_W        = 7;
    localparam int STATUS_W         = 3;
    localparam int KEY_W            = 64;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd64;

    typedef enum logic [1:0] {
        K_BEGIN = 2'd0,
        K_MARK  = 2'd1,
        K_ABORT = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACQUIRED   = 3'd0,
        ST_DELIVERED  = 3'd1,
        ST_PROCESSING = 3'd2,
        ST_INVALID    = 3'd3,
        ST_FULL       = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC,
        S_TRIM_RD,
        S_TRIM_POP,
        S_PUSH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic alloc;
        logic release_slot;
        logic mark;
    } t_cell_cmd;

endpackage

// ----- sv/ddt_cell.sv -----
// ----------------------------------------------------------------------------
// Dedup table cell
// One table slot: used flag, key and delivered flag, with a key compare.
// ----------------------------------------------------------------------------
module ddt_cell #(
    parameter int SW  = 6,
    parameter int IDX = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [ddt_pkg::KEY_W-1:0] i_key,
    input  logic [SW-1:0]             i_sel,
    input  ddt_pkg::t_cell_cmd        i_cmd,
    output logic                      o_hit,
    output logic                      o_used,
    output logic                      o_dlv
);

    localparam logic [SW-1:0] MY_IDX = SW'(IDX);

    logic                      r_used;
    logic                      r_dlv;
    logic [ddt_pkg::KEY_W-1:0] r_key;
    logic                      w_me;

    assign w_me = (i_sel == MY_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (w_me && i_cmd.alloc) begin
            r_used <= 1'b1;
        end else if (w_me && i_cmd.release_slot) begin
            r_used <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_me && i_cmd.alloc) begin
            r_key <= i_key;
            r_dlv <= 1'b0;
        end else if (w_me && i_cmd.mark) begin
            r_dlv <= 1'b1;
        end
    end

    assign o_hit  = r_used && (r_key == i_key);
    assign o_used = r_used;
    assign o_dlv  = r_dlv;

endmodule

// ----- sv/ddt_penc.sv -----
// ----------------------------------------------------------------------------
// Dedup table priority encoder
// Index of the lowest set bit of a request vector, and whether any is set.
// ----------------------------------------------------------------------------
module ddt_penc #(
    parameter int N  = 64,
    parameter int SW = 6
) (
    input  logic [N-1:0]  i_req,
    output logic          o_found,
    output logic [SW-1:0] o_idx
);

    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (i_req[i]) begin
                o_found = 1'b1;
                o_idx   = SW'(i);
            end
        end
    end

endmodule

// ----- sv/delivery_dedup_table.sv -----
// ----------------------------------------------------------------------------
// Delivery dedup table
// Keyed identity table with a window of delivered entries, oldest first.
// ----------------------------------------------------------------------------
// One transaction in, one result out. A begin, an abort or a mark of an
// entry already delivered goes from accept to result through parallel
// key match over the row of slot cells, update and result register. A
// mark that queues an entry first forgets the oldest delivered entries
// to make room and then pushes its slot; each of those pops is one read
// of the delivered-slot memory and a release of the slot if it is live.
// Items are handled one at a time; the next is accepted in the cycle
// after the previous result has been handed to the result register. The
// window register is written at any time; write it only while no
// transaction is in flight. 0 acts as 1 and values above WINDOW_DEPTH act
// as WINDOW_DEPTH. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`include "delivery_dedup_table_defines.svh"

module delivery_dedup_table #(
    parameter int TABLE_SLOTS  = ddt_pkg::TABLE_SLOTS_DEF,
    parameter int WINDOW_DEPTH = ddt_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [63:0]               i_s_axis_tdata,  // identity_key
    input  logic [2:0]                i_s_axis_tuser,  // kind[1:0], identity_ok[2]
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // status[2:0], ok[3], entries_in_use[10:4], delivered_in_window[17:11], zero
    output logic [23:0]               o_m_axis_tdata,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [ddt_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int SW   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int NP   = 2 ** SW;
    localparam int CW   = $clog2(TABLE_SLOTS + 1);
    localparam int QW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int QCW  = $clog2(WINDOW_DEPTH + 1);
    localparam int LW   = (QCW > ddt_pkg::CFG_W) ? QCW : ddt_pkg::CFG_W;
    localparam logic [CW-1:0]  SLOTS_C  = CW'(TABLE_SLOTS);
    localparam logic [LW-1:0]  DEPTH_L  = LW'(WINDOW_DEPTH);
    localparam logic [QCW:0]   DEPTH_S  = (QCW + 1)'(WINDOW_DEPTH);
    localparam logic [QW-1:0]  HEAD_TOP = QW'(WINDOW_DEPTH - 1);

    ddt_pkg::t_state r_state, n_state;

    logic [ddt_pkg::CFG_W-1:0]  r_window;
    logic [1:0]                 r_kind;
    logic [ddt_pkg::KEY_W-1:0]  r_key;
    logic                       r_idok;
    logic                       r_hit_found, r_hit_dlv, r_free_found;
    logic [SW-1:0]              r_hit_idx, r_free_idx;
    logic [ddt_pkg::STATUS_W-1:0] r_status;
    logic                       r_ok;
    logic [CW-1:0]              r_used_cnt;
    logic [QCW-1:0]             r_qcount;
    logic [QW-1:0]              r_qhead;
    logic [SW-1:0]              r_rdata;
    logic [SW-1:0]              r_qmem [WINDOW_DEPTH];
    logic                       r_out_valid;
    logic [23:0]                r_out_data;

    logic [TABLE_SLOTS-1:0]     w_hit, w_used, w_dlv;
    logic [NP-1:0]              w_used_pad, w_dlv_pad, w_hit_pad;
    logic                       w_pen_hit_found, w_pen_free_found;
    logic [SW-1:0]              w_pen_hit_idx, w_pen_free_idx;

    ddt_pkg::t_cell_cmd         w_cmd;
    logic [SW-1:0]              w_sel;
    logic                       w_used_inc, w_used_dec;
    logic                       w_set_result;
    logic [ddt_pkg::STATUS_W-1:0] w_status;
    logic                       w_ok;
    logic                       w_to_trim;
    logic                       w_rd_en, w_pop, w_push, w_load_out;
    logic                       w_old_live;
    logic [LW-1:0]              w_lim;
    logic                       w_need_pop;
    logic [QCW:0]               w_wsum;
    logic [QW-1:0]              w_waddr;
    logic [31:0]                w_used32, w_q32;

    // ---- slot cells ----
    for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
        ddt_cell #(.SW(SW), .IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (r_key),
            .i_sel   (w_sel),
            .i_cmd   (w_cmd),
            .o_hit   (w_hit[g]),
            .o_used  (w_used[g]),
            .o_dlv   (w_dlv[g])
        );
    end

    assign w_used_pad = NP'(w_used);
    assign w_dlv_pad  = NP'(w_dlv);
    assign w_hit_pad  = NP'(w_hit);

    ddt_penc #(.N(TABLE_SLOTS), .SW(SW)) u_hit_enc (
        .i_req   (w_hit),
        .o_found (w_pen_hit_found),
        .o_idx   (w_pen_hit_idx)
    );

    ddt_penc #(.N(TABLE_SLOTS), .SW(SW)) u_free_enc (
        .i_req   (~w_used),
        .o_found (w_pen_free_found),
        .o_idx   (w_pen_free_idx)
    );

    // ---- window limit and queue addressing ----
    always_comb begin
        if (r_window == '0) begin
            w_lim = LW'(1);
        end else if (LW'(r_window) > DEPTH_L) begin
            w_lim = DEPTH_L;
        end else begin
            w_lim = LW'(r_window);
        end
    end

    assign w_need_pop = (r_qcount != '0) && (LW'(r_qcount) >= w_lim);
    assign w_wsum     = (QCW + 1)'(r_qhead) + (QCW + 1)'(r_qcount);
    assign w_waddr    = (w_wsum >= DEPTH_S) ? QW'(w_wsum - DEPTH_S) : QW'(w_wsum);
    assign w_old_live = w_used_pad[r_rdata] && w_dlv_pad[r_rdata];

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ddt_pkg::S_IDLE:     if (i_s_axis_tvalid) n_state = ddt_pkg::S_LOOK;
            ddt_pkg::S_LOOK:     n_state = ddt_pkg::S_EXEC;
            ddt_pkg::S_EXEC:     n_state = w_to_trim ? ddt_pkg::S_TRIM_RD : ddt_pkg::S_DONE;
            ddt_pkg::S_TRIM_RD:  n_state = w_need_pop ? ddt_pkg::S_TRIM_POP : ddt_pkg::S_PUSH;
            ddt_pkg::S_TRIM_POP: n_state = ddt_pkg::S_TRIM_RD;
            ddt_pkg::S_PUSH:     n_state = ddt_pkg::S_DONE;
            ddt_pkg::S_DONE:     if (!r_out_valid || i_m_axis_tready) n_state = ddt_pkg::S_IDLE;
            default:             n_state = ddt_pkg::S_IDLE;
        endcase
    end

    // ---- outputs of the sequencer ----
    always_comb begin
        w_cmd        = '0;
        w_sel        = r_hit_idx;
        w_used_inc   = 1'b0;
        w_used_dec   = 1'b0;
        w_set_result = 1'b0;
        w_status     = ddt_pkg::ST_ACQUIRED;
        w_ok         = 1'b0;
        w_to_trim    = 1'b0;
        w_rd_en      = 1'b0;
        w_pop        = 1'b0;
        w_push       = 1'b0;
        w_load_out   = 1'b0;
        unique case (r_state)
            ddt_pkg::S_EXEC: begin
                w_set_result = 1'b1;
                unique case (ddt_pkg::t_kind'(r_kind))
                    ddt_pkg::K_BEGIN: begin
                        if (!r_idok) begin
                            w_status = ddt_pkg::ST_INVALID;
                        end else if (r_hit_found) begin
                            w_status = r_hit_dlv ? ddt_pkg::ST_DELIVERED
                                                 : ddt_pkg::ST_PROCESSING;
                        end else if (r_used_cnt >= SLOTS_C || !r_free_found) begin
                            w_status = ddt_pkg::ST_FULL;
                        end else begin
                            w_sel      = r_free_idx;
                            w_cmd.alloc = 1'b1;
                            w_used_inc = 1'b1;
                        end
                    end
                    ddt_pkg::K_MARK: begin
                        if (r_idok && r_hit_found) begin
                            w_ok = 1'b1;
                            if (!r_hit_dlv) begin
                                w_cmd.mark = 1'b1;
                                w_to_trim  = 1'b1;
                            end
                        end
                    end
                    ddt_pkg::K_ABORT: begin
                        if (r_idok) begin
                            if (!r_hit_found) begin
                                w_ok = 1'b1;
                            end else if (!r_hit_dlv) begin
                                w_ok               = 1'b1;
                                w_cmd.release_slot = 1'b1;
                                w_used_dec         = 1'b1;
                            end
                        end
                    end
                    ddt_pkg::K_NONE: begin
                        w_ok = 1'b0;
                    end
                    default: begin
                        w_ok = 1'b0;
                    end
                endcase
            end
            ddt_pkg::S_TRIM_RD: begin
                w_rd_en = w_need_pop;
            end
            ddt_pkg::S_TRIM_POP: begin
                // forget the oldest delivered entry
                w_pop = 1'b1;
                w_sel = r_rdata;
                if (w_old_live) begin
                    w_cmd.release_slot = 1'b1;
                    w_used_dec         = 1'b1;
                end
            end
            ddt_pkg::S_PUSH: begin
                w_push = 1'b1;
            end
            ddt_pkg::S_DONE: begin
                w_load_out = !r_out_valid || i_m_axis_tready;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ddt_pkg::S_IDLE;
            r_window    <= ddt_pkg::WINDOW_RESET;
            r_used_cnt  <= '0;
            r_qcount    <= '0;
            r_qhead     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_window <= i_cfg_data;
            end
            if (w_used_inc) begin
                r_used_cnt <= r_used_cnt + CW'(1);
            end else if (w_used_dec) begin
                r_used_cnt <= r_used_cnt - CW'(1);
            end
            if (w_pop) begin
                r_qhead  <= (r_qhead == HEAD_TOP) ? '0 : r_qhead + QW'(1);
                r_qcount <= r_qcount - QCW'(1);
            end else if (w_push) begin
                r_qcount <= r_qcount + QCW'(1);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ddt_pkg::S_IDLE && i_s_axis_tvalid) begin
            r_key  <= i_s_axis_tdata;
            r_kind <= i_s_axis_tuser[1:0];
            r_idok <= i_s_axis_tuser[2];
        end
        if (r_state == ddt_pkg::S_LOOK) begin
            r_hit_found  <= w_pen_hit_found;
            r_hit_idx    <= w_pen_hit_idx;
            r_hit_dlv    <= w_dlv_pad[w_pen_hit_idx];
            r_free_found <= w_pen_free_found;
            r_free_idx   <= w_pen_free_idx;
        end
        if (w_set_result) begin
            r_status <= w_status;
            r_ok     <= w_ok;
        end
        if (w_load_out) begin
            r_out_data <= {6'd0, w_q32[6:0], w_used32[6:0], r_ok, r_status};
        end
    end

    // delivered-slot memory
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_qmem[w_waddr] <= r_hit_idx;
        end
        if (w_rd_en) begin
            r_rdata <= r_qmem[r_qhead];
        end
    end

    assign w_used32 = 32'(r_used_cnt);
    assign w_q32    = 32'(r_qcount);

    assign o_s_axis_tready = (r_state == ddt_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    // ---- checks ----
    `DDT_ASSERT(a_used_count, i_clk, i_rst_n, (32'(r_used_cnt) == $countones(w_used)))
    `DDT_ASSERT(a_queue_bound, i_clk, i_rst_n, (32'(r_qcount) <= 32'(WINDOW_DEPTH)))
    `DDT_ASSERT(a_queue_le_used, i_clk, i_rst_n, (32'(r_qcount) <= 32'(r_used_cnt)))
    `DDT_ASSERT(a_hit_unique, i_clk, i_rst_n, $onehot0(w_hit_pad))
    `DDT_ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, w_load_out, r_out_valid)

endmodule

// ----- tb/delivery_dedup_table_test.sv -----
// ----------------------------------------------------------------------------
// Delivery dedup table testbench
// Drives begin, mark-delivered, abort and no-op transactions with random gaps
// and stalls. A behavioral table predicts each result, which is checked field
// by field. The window register is swept through its extremes between phases.
// ----------------------------------------------------------------------------
module delivery_dedup_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 64;
    localparam int DEPTH = 64;
    localparam int STALL_LIMIT = 5000;
    localparam int RING = 2048;

    // packed from the top bit down: field order matches tdata from bit 17 to 0
    typedef struct packed {
        logic [6:0]       queued;
        logic [6:0]       in_use;
        logic             ok;
        ddt_pkg::t_status status;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata = '0;
    logic [2:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [ddt_pkg::CFG_W-1:0] i_cfg_data = '0;

    delivery_dedup_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata), .i_s_axis_tuser(i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the table
    logic [6:0]  window_reg = ddt_pkg::WINDOW_RESET;
    logic        slot_busy [SLOTS];
    logic [63:0] slot_ident [SLOTS];
    logic        slot_done [SLOTS];
    int          done_fifo [DEPTH];
    int          fifo_head = 0;
    int          fifo_len = 0;
    int          busy_count = 0;

    // expected results, written at input accept and read at result accept
    t_result     exp_ring [RING];
    int          exp_wr = 0;
    int          exp_rd = 0;
    int          error_count = 0;
    bit          quiet = 1'b0;
    int          hold_request = 0;
    logic [63:0] key_pool [80];

    function automatic t_result predict(ddt_pkg::t_kind op, logic [63:0] ident, logic good);
        int hit;
        int lim;
        int s;
        int old;
        t_result r;
        r = '0;
        hit = -1;
        for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && slot_busy[i] && slot_ident[i] == ident) hit = i;
        case (op)
            ddt_pkg::K_BEGIN: begin
                if (!good) begin
                    r.status = ddt_pkg::ST_INVALID;
                end else if (hit >= 0) begin
                    r.status = slot_done[hit] ? ddt_pkg::ST_DELIVERED
                                              : ddt_pkg::ST_PROCESSING;
                end else if (busy_count >= SLOTS) begin
                    r.status = ddt_pkg::ST_FULL;
                end else begin
                    s = 0;
                    while (slot_busy[s]) s++;
                    slot_busy[s] = 1'b1;
                    slot_ident[s] = ident;
                    slot_done[s] = 1'b0;
                    busy_count++;
                    r.status = ddt_pkg::ST_ACQUIRED;
                end
            end
            ddt_pkg::K_MARK: begin
                if (good && hit >= 0) begin
                    r.ok = 1'b1;
                    if (!slot_done[hit]) begin
                        slot_done[hit] = 1'b1;
                        lim = (window_reg == 0) ? 1 : (window_reg > DEPTH) ? DEPTH : window_reg;
                        // forget oldest delivered entries to leave one place
                        while (fifo_len > 0 && fifo_len >= lim) begin
                            old = done_fifo[fifo_head];
                            fifo_head = (fifo_head + 1) % DEPTH;
                            fifo_len--;
                            if (slot_busy[old] && slot_done[old]) begin
                                slot_busy[old] = 1'b0;
                                busy_count--;
                            end
                        end
                        done_fifo[(fifo_head + fifo_len) % DEPTH] = hit;
                        fifo_len++;
                    end
                end
            end
            ddt_pkg::K_ABORT: begin
                if (good) begin
                    if (hit < 0) begin
                        r.ok = 1'b1;
                    end else if (!slot_done[hit]) begin
                        slot_busy[hit] = 1'b0;
                        busy_count--;
                        r.ok = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.in_use = busy_count[6:0];
        r.queued = fifo_len[6:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (quiet || roll < 65) return 0;
        if (roll < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic send_item(ddt_pkg::t_kind op, logic [63:0] ident, logic good);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= ident;
        i_s_axis_tuser <= {good, op};
        do @(posedge i_clk); while (!o_s_axis_tready);
        exp_ring[exp_wr % RING] = predict(op, ident, good);
        exp_wr++;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (exp_wr != exp_rd) @(posedge i_clk);
    endtask

    task automatic write_window(logic [6:0] value);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        window_reg = value;
    endtask

    function automatic logic [63:0] random_key();
        return {$urandom, $urandom};
    endfunction

    task automatic random_items(int count, int begin_pct, int bad_pct);
        int roll;
        logic [63:0] ident;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            ident = key_pool[$urandom_range(79)];
            if ($urandom_range(99) < 3) key_pool[$urandom_range(79)] = random_key();
            if ($urandom_range(99) < 5) ident = random_key();
            if (roll < begin_pct)
                send_item(ddt_pkg::K_BEGIN, ident, $urandom_range(99) >= bad_pct);
            else if (roll < begin_pct + (100 - begin_pct) * 2 / 3)
                send_item(ddt_pkg::K_MARK, ident, $urandom_range(99) >= bad_pct);
            else if (roll < 97)
                send_item(ddt_pkg::K_ABORT, ident, $urandom_range(99) >= bad_pct);
            else
                send_item(ddt_pkg::K_NONE, ident, $urandom_range(1));
        end
    endtask

    task automatic test_directed();
        logic [63:0] k0;
        logic [63:0] k1;
        k0 = '0;
        k1 = '1;
        quiet = 1'b1;
        send_item(ddt_pkg::K_BEGIN, k0, 1'b0);
        send_item(ddt_pkg::K_BEGIN, k0, 1'b1);
        send_item(ddt_pkg::K_BEGIN, k1, 1'b1);
        send_item(ddt_pkg::K_BEGIN, k0, 1'b1);
        send_item(ddt_pkg::K_MARK, k0, 1'b1);
        send_item(ddt_pkg::K_MARK, k0, 1'b1);
        send_item(ddt_pkg::K_BEGIN, k0, 1'b1);
        send_item(ddt_pkg::K_ABORT, k0, 1'b1);
        send_item(ddt_pkg::K_ABORT, 64'h5a5a_a5a5_0f0f_f0f0, 1'b1);
        send_item(ddt_pkg::K_MARK, 64'h5a5a_a5a5_0f0f_f0f0, 1'b1);
        send_item(ddt_pkg::K_MARK, k1, 1'b0);
        send_item(ddt_pkg::K_ABORT, k1, 1'b0);
        send_item(ddt_pkg::K_NONE, k1, 1'b1);
        send_item(ddt_pkg::K_ABORT, k1, 1'b1);
        send_item(ddt_pkg::K_BEGIN, k1, 1'b1);
        quiet = 1'b0;
    endtask

    task automatic test_table_full();
        logic [63:0] ident;
        write_window(7'd64);
        while (busy_count < SLOTS) send_item(ddt_pkg::K_BEGIN, random_key(), 1'b1);
        ident = random_key();
        send_item(ddt_pkg::K_BEGIN, ident, 1'b1);
        send_item(ddt_pkg::K_MARK, slot_ident[3], 1'b1);
        send_item(ddt_pkg::K_ABORT, slot_ident[9], 1'b1);
        send_item(ddt_pkg::K_BEGIN, ident, 1'b1);
    endtask

    task automatic test_receiver_hold();
        drain();
        hold_request = 300;
        random_items(12, 40, 5);
        drain();
    endtask

    task automatic test_window_sweep();
        write_window(7'd1);
        random_items(150, 40, 5);
        write_window(7'd0);
        random_items(100, 40, 5);
        write_window(7'd127);
        random_items(150, 45, 5);
        write_window(7'd3);
        random_items(150, 40, 5);
    endtask

    task automatic test_random();
        write_window(7'd64);
        random_items(350, 45, 4);
        write_window(7'd16);
        random_items(150, 40, 4);
    endtask

    // result side: check and throttle
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        int hold_left;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[17:0];
            if (exp_wr == exp_rd) begin
                $error("unexpected result %h", o_m_axis_tdata);
                error_count++;
            end else begin
                want = exp_ring[exp_rd % RING];
                exp_rd++;
                if (got.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    error_count++;
                end
                if (got.ok !== want.ok) begin
                    $error("ok expected %0d actual %0d", want.ok, got.ok);
                    error_count++;
                end
                if (got.in_use !== want.in_use) begin
                    $error("entries_in_use expected %0d actual %0d", want.in_use, got.in_use);
                    error_count++;
                end
                if (got.queued !== want.queued) begin
                    $error("delivered_in_window expected %0d actual %0d",
                           want.queued, got.queued);
                    error_count++;
                end
            end
        end
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            // hold off for a random stretch, mostly short
            hold_left = pick_gap();
            if (hold_left > 0) begin
                hold_request = hold_left - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // stop the run if nothing moves for too long
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("delivery_dedup_table_test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            slot_busy[i] = 1'b0;
            slot_ident[i] = '0;
            slot_done[i] = 1'b0;
        end
        for (int i = 0; i < 80; i++) key_pool[i] = random_key();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_table_full();
        test_receiver_hold();
        test_window_sweep();
        test_random();
        drain();
        repeat (30) @(posedge i_clk);
        if (error_count == 0 && exp_wr == exp_rd) begin
            $display("delivery_dedup_table_test passed");
        end else begin
            $display("delivery_dedup_table_test failed");
        end
        $finish;
    end
endmodule
